>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante must be followed by cons in the same cycle
`define PFB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cond must never hold
`define PFB_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

>>> rtl/pfb_pkg.sv
package pfb_pkg;

    localparam logic [1:0] OP_SET_PIXEL = 2'd0;
    localparam logic [1:0] OP_FILL_RECT = 2'd1;
    localparam logic [1:0] OP_FILL_ALL  = 2'd2;
    localparam logic [1:0] OP_READ_BYTE = 2'd3;

    localparam logic [7:0] FULL_MASK = 8'hFF;
    localparam logic [3:0] PAGE_BITS = 4'd8;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] x_first;
        logic [7:0] y_first;
        logic [7:0] x_second;
        logic [7:0] y_second;
        logic [7:0] pattern;
        logic       pixel_on;
        logic [4:0] read_page;
    } pfb_req_t;

    typedef struct packed {
        logic [7:0] read_byte;
        logic       status;
    } pfb_rsp_t;

    typedef struct packed {
        logic load_in;
        logic setup;
        logic setup_clear;
        logic rd_en;
        logic wr_en;
        logic advance;
        logic capture;
        logic load_out;
    } pfb_cmd_t;

    typedef struct packed {
        logic none;
        logic need_read;
        logic is_read;
        logic last;
        logic out_free;
    } pfb_sts_t;

    // rows lo..hi-1 of a page byte; hi runs 1..8
    function automatic logic [7:0] byte_mask(input logic [2:0] lo, input logic [3:0] hi);
        logic [7:0] below_hi;
        logic [7:0] below_lo;
        below_hi = hi[3] ? FULL_MASK : 8'((9'd1 << hi[2:0]) - 9'd1);
        below_lo = 8'((9'd1 << lo) - 9'd1);
        return below_hi & ~below_lo;
    endfunction

endpackage

>>> rtl/pfb_ram.sv
module pfb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wr_data,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[addr];
        end
    end

endmodule

>>> rtl/pfb_ctrl.sv
`include "assert_macros.svh"

module pfb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  pfb_pkg::pfb_sts_t sts,
    output pfb_pkg::pfb_cmd_t cmd
);

    import pfb_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_SETUP,
        S_STEP,
        S_MERGE,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   clearing_reg, clearing_next;
    logic   stall_reg, stall_next;

    always_comb
    begin
        state_next    = state_reg;
        clearing_next = clearing_reg;
        cmd           = '0;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.setup_clear = 1'b1;
                clearing_next   = 1'b1;
                state_next      = S_STEP;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                if (sts.none)
                begin
                    state_next = S_FINISH;
                end
                else if (sts.need_read)
                begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_MERGE;
                end
                else
                begin
                    cmd.wr_en = 1'b1;
                    if (sts.last)
                    begin
                        state_next    = clearing_reg ? S_IDLE : S_FINISH;
                        clearing_next = 1'b0;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                    end
                end
            end
            S_MERGE:
            begin
                if (sts.is_read)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_FINISH;
                end
                else
                begin
                    cmd.wr_en = 1'b1;
                    if (sts.last)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        state_next  = S_STEP;
                    end
                end
            end
            S_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
        stall_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_INIT;
            clearing_reg <= 1'b0;
            stall_reg    <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            clearing_reg <= clearing_next;
            stall_reg    <= stall_next;
        end
    end

    assign req_stall = stall_reg;

    `PFB_ASSERT_NEVER(a_rd_wr_excl, clk, rst_n, cmd.rd_en && cmd.wr_en, "read and write together")
    `PFB_ASSERT_IMP(a_capture_after_rd, clk, rst_n, cmd.capture, $past(cmd.rd_en), "capture w/o read")
    `PFB_ASSERT_IMP(a_no_result_clear, clk, rst_n, clearing_reg, !cmd.load_out, "result while clearing")

endmodule

>>> rtl/pfb_dp.sv
`include "assert_macros.svh"

module pfb_dp #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  pfb_pkg::pfb_req_t req,
    output pfb_pkg::pfb_rsp_t rsp,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    input  pfb_pkg::pfb_cmd_t cmd,
    output pfb_pkg::pfb_sts_t sts
);

    import pfb_pkg::*;

    localparam int DEPTH  = COLUMNS * PAGES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int ROWS   = PAGES * 8;

    pfb_req_t   hold_reg;
    logic [7:0] col_lo_reg, col_last_reg, col_reg;
    logic [4:0] page_lo_reg, page_last_reg, page_reg;
    logic [2:0] lo_reg;
    logic [3:0] hi_reg;
    logic [7:0] pat_reg, byte_reg;
    logic       none_reg, rd_mode_reg, stat_reg;
    pfb_rsp_t   rsp_reg;
    logic       rsp_valid_reg;

    // setup values
    logic [7:0] xa, xb, x2, ya, yb, y2, y2m1;
    logic [7:0] s_col_lo, s_col_last, s_pat;
    logic [4:0] s_page_lo, s_page_last;
    logic [2:0] s_lo;
    logic [3:0] s_hi;
    logic       s_none, s_stat, s_rd_mode, oor;

    logic [2:0]        lo_eff;
    logic [3:0]        hi_eff;
    logic [7:0]        mask, rd_data, wr_data;
    logic [ADDR_W-1:0] addr;
    logic              col_end;

    always_comb
    begin
        xa   = (hold_reg.x_first < hold_reg.x_second) ? hold_reg.x_first : hold_reg.x_second;
        xb   = (hold_reg.x_first < hold_reg.x_second) ? hold_reg.x_second : hold_reg.x_first;
        ya   = (hold_reg.y_first < hold_reg.y_second) ? hold_reg.y_first : hold_reg.y_second;
        yb   = (hold_reg.y_first < hold_reg.y_second) ? hold_reg.y_second : hold_reg.y_first;
        x2   = (xb < 8'(COLUMNS)) ? xb : 8'(COLUMNS);
        y2   = (yb < 8'(ROWS)) ? yb : 8'(ROWS);
        y2m1 = y2 - 8'd1;
        oor  = 1'b0;

        s_col_lo    = 8'd0;
        s_col_last  = 8'(COLUMNS - 1);
        s_page_lo   = 5'd0;
        s_page_last = 5'(PAGES - 1);
        s_lo        = 3'd0;
        s_hi        = PAGE_BITS;
        s_pat       = hold_reg.pattern;
        s_none      = 1'b0;
        s_stat      = 1'b0;
        s_rd_mode   = 1'b0;
        unique case (hold_reg.operation)
            OP_SET_PIXEL:
            begin
                oor         = (hold_reg.x_first >= 8'(COLUMNS)) || (hold_reg.y_first >= 8'(ROWS));
                s_col_lo    = hold_reg.x_first;
                s_col_last  = hold_reg.x_first;
                s_page_lo   = hold_reg.y_first[7:3];
                s_page_last = hold_reg.y_first[7:3];
                s_lo        = hold_reg.y_first[2:0];
                s_hi        = {1'b0, hold_reg.y_first[2:0]} + 4'd1;
                s_pat       = {8{hold_reg.pixel_on}};
                s_none      = oor;
                s_stat      = oor;
            end
            OP_FILL_RECT:
            begin
                s_col_lo    = xa;
                s_col_last  = x2 - 8'd1;
                s_page_lo   = ya[7:3];
                s_page_last = y2m1[7:3];
                s_lo        = ya[2:0];
                s_hi        = {1'b0, y2m1[2:0]} + 4'd1;
                s_none      = (xa >= x2) || (ya >= y2);
            end
            OP_FILL_ALL:
            begin
                s_none = 1'b0;
            end
            OP_READ_BYTE:
            begin
                oor         = (hold_reg.x_first >= 8'(COLUMNS)) || (hold_reg.read_page >= 5'(PAGES));
                s_col_lo    = hold_reg.x_first;
                s_col_last  = hold_reg.x_first;
                s_page_lo   = hold_reg.read_page;
                s_page_last = hold_reg.read_page;
                s_none      = oor;
                s_stat      = oor;
                s_rd_mode   = 1'b1;
            end
            default:
            begin
                s_none = 1'b1;
            end
        endcase
    end

    // top and bottom pages of a span get partial masks
    assign lo_eff  = (page_reg == page_lo_reg) ? lo_reg : 3'd0;
    assign hi_eff  = (page_reg == page_last_reg) ? hi_reg : PAGE_BITS;
    assign mask    = byte_mask(lo_eff, hi_eff);
    assign addr    = ADDR_W'(col_reg) * ADDR_W'(PAGES) + ADDR_W'(page_reg);
    assign wr_data = (rd_data & ~mask) | (pat_reg & mask);
    assign col_end = (col_reg == col_last_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            hold_reg <= req;
        end
        if (cmd.setup || cmd.setup_clear)
        begin
            col_lo_reg    <= cmd.setup_clear ? 8'd0 : s_col_lo;
            col_last_reg  <= cmd.setup_clear ? 8'(COLUMNS - 1) : s_col_last;
            page_lo_reg   <= cmd.setup_clear ? 5'd0 : s_page_lo;
            page_last_reg <= cmd.setup_clear ? 5'(PAGES - 1) : s_page_last;
            lo_reg        <= cmd.setup_clear ? 3'd0 : s_lo;
            hi_reg        <= cmd.setup_clear ? PAGE_BITS : s_hi;
            pat_reg       <= cmd.setup_clear ? 8'd0 : s_pat;
            none_reg      <= cmd.setup_clear ? 1'b0 : s_none;
            stat_reg      <= cmd.setup_clear ? 1'b0 : s_stat;
            rd_mode_reg   <= cmd.setup_clear ? 1'b0 : s_rd_mode;
            col_reg       <= cmd.setup_clear ? 8'd0 : s_col_lo;
            page_reg      <= cmd.setup_clear ? 5'd0 : s_page_lo;
            byte_reg      <= 8'd0;
        end
        else if (cmd.advance)
        begin
            if (col_end)
            begin
                col_reg  <= col_lo_reg;
                page_reg <= page_reg + 5'd1;
            end
            else
            begin
                col_reg <= col_reg + 8'd1;
            end
        end
        if (cmd.capture)
        begin
            byte_reg <= rd_data;
        end
        if (cmd.load_out)
        begin
            rsp_reg <= '{read_byte: byte_reg, status: stat_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    pfb_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (cmd.wr_en),
        .rd_en   (cmd.rd_en),
        .addr    (addr),
        .wr_data (wr_data),
        .rd_data (rd_data)
    );

    assign sts.none      = none_reg;
    assign sts.need_read = rd_mode_reg || (mask != FULL_MASK);
    assign sts.is_read   = rd_mode_reg;
    assign sts.last      = col_end && (page_reg == page_last_reg);
    assign sts.out_free  = !rsp_valid_reg || !rsp_stall;

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    `PFB_ASSERT_IMP(a_wr_in_range, clk, rst_n, cmd.wr_en, (col_reg < 8'(COLUMNS)) && (page_reg < 5'(PAGES)), "write outside store")
    `PFB_ASSERT_IMP(a_rd_in_range, clk, rst_n, cmd.rd_en, (col_reg < 8'(COLUMNS)) && (page_reg < 5'(PAGES)), "read outside store")

endmodule

>>> rtl/page_frame_buffer_draw.sv
// channel | handshake              | word
// req     | req_valid / req_stall  | pfb_req_t: operation, corners, pattern, pixel, page
// rsp     | rsp_valid / rsp_stall  | pfb_rsp_t: read_byte, status
//
// Set pixel and read byte do a store read, then a write (set pixel) or a capture (read byte).
// Fill all writes every store byte, one store write per cycle.
// Fill rectangle writes full page bytes directly and masked top/bottom bytes by read-modify-write
// through the single store port. Rejected or empty operations touch no store byte.
// After reset the store is swept to zero with req_stall high.
// A finished word waits in the rsp register; the next req word is taken meanwhile.
module page_frame_buffer_draw #(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  pfb_pkg::pfb_req_t req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output pfb_pkg::pfb_rsp_t rsp
);

    import pfb_pkg::*;

    pfb_cmd_t cmd;
    pfb_sts_t sts;

    pfb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    pfb_dp #(
        .COLUMNS(COLUMNS),
        .PAGES  (PAGES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
